@@ rtl/core/mwl_pkg.sv @@
`default_nettype none

package mwl_pkg;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int FREQ_W  = 24;
  localparam int PHASE_W = 32;
  localparam int FRAC_W  = 16;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_SAMPLE = 2'd0,
    CMD_WRITE_DESC   = 2'd1,
    CMD_READ         = 2'd2,
    CMD_IDLE         = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/mwl_interp.sv @@
`default_nettype none

module mwl_interp import mwl_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int TSEL_W      = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] a,
  input  wire logic signed [SAMPLE_BITS-1:0] b,
  input  wire logic        [FRAC_W-1:0]      frac,
  input  wire logic        [TSEL_W-1:0]      item_table,
  output logic                               done,
  output logic signed      [SAMPLE_BITS-1:0] sample_out,
  output logic             [TSEL_W-1:0]      table_used
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;
  localparam int ACC_W  = SAMPLE_BITS + FRAC_W + 2;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (FRAC_W - 1);

  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      prod_next;
  logic                          s5_valid;
  logic signed [PROD_W-1:0]      s5_prod;
  logic signed [SAMPLE_BITS-1:0] s5_a;
  logic        [TSEL_W-1:0]      s5_table;
  logic signed [ACC_W-1:0]       acc;

  // slope times fraction: a + (b - a) * f
  assign diff      = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
  assign prod_next = diff * $signed({1'b0, frac});

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_prod  <= prod_next;
    s5_a     <= a;
    s5_table <= item_table;
  end

  // add base, round half up, floor shift
  assign acc = {{2{s5_a[SAMPLE_BITS-1]}}, s5_a, {FRAC_W{1'b0}}} + ACC_W'(s5_prod) + ROUND;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    sample_out <= acc[FRAC_W +: SAMPLE_BITS];
    table_used <= s5_table;
  end

endmodule

`default_nettype wire

@@ rtl/core/mipmap_wavetable_lookup.sv @@
`default_nettype none

// Band-limited wavetable read with mipmap table selection.
// Request channel: a request is taken at a rising edge with start high and
// busy low. busy is high only during reset, so one request can be taken in
// every cycle. command selects a sample word write, a descriptor write
// (length and exclusive upper frequency bound) or a read.
// Result channel: for each read, done is high for exactly one cycle with
// sample_out and table_used valid; writes give no result. The receiver
// cannot stall, and nothing in the pipeline ever waits.
// Pipeline: a read passes through six register stages on its way to the
// result: input, table select, phase by length product, wave memory read,
// interpolation product, output.
// Throughput: one request per cycle, sustained.
// Requests take effect in order: descriptor writes commit in the select
// stage and sample writes in the memory stage, exactly where reads look.
// Configuration: cfg_write loads the number of tables in use from cfg_data
// (0 acts as 1, above MAX_TABLES acts as MAX_TABLES); write it while idle.
// Reset: descriptors return to full length and all-ones bounds, all tables
// are in use and the pipeline empties; wave memory is not cleared.
module mipmap_wavetable_lookup import mwl_pkg::*; #(
  parameter int MAX_TABLES  = 8,
  parameter int MAX_LENGTH  = 4096,
  parameter int SAMPLE_BITS = 16,
  localparam int TSEL_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1,
  localparam int CNT_W  = $clog2(MAX_TABLES + 1),
  localparam int IDX_W  = $clog2(MAX_LENGTH),
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic        [CMD_W-1:0]       command,
  input  wire logic        [TSEL_W-1:0]      table_select,
  input  wire logic        [IDX_W-1:0]       sample_index,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
  input  wire logic        [LEN_W-1:0]       table_length,
  input  wire logic        [FREQ_W-1:0]      frequency_bound,
  input  wire logic        [FREQ_W-1:0]      frequency,
  input  wire logic        [PHASE_W-1:0]     phase,
  input  wire logic                          cfg_write,
  input  wire logic        [CNT_W-1:0]       cfg_data,
  output logic                               done,
  output logic signed      [SAMPLE_BITS-1:0] sample_out,
  output logic             [TSEL_W-1:0]      table_used
);

  localparam int ADDR_W    = TSEL_W + IDX_W;
  localparam int MEM_DEPTH = MAX_TABLES << IDX_W;
  localparam int PROD_W    = PHASE_W + LEN_W;
  localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_TABLES);
  localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(MAX_LENGTH);
  localparam logic [TSEL_W:0]   TABLES_LIM = (TSEL_W + 1)'(MAX_TABLES);
  localparam logic [IDX_W:0]    IDX_LIM    = (IDX_W + 1)'(MAX_LENGTH);

  logic                     accept;
  logic [CNT_W-1:0]         tables_in_use;
  logic [LEN_W-1:0]         length_table [MAX_TABLES];
  logic [FREQ_W-1:0]        bound_table  [MAX_TABLES];

  // stage 1: table select
  logic                          s1_valid;
  cmd_t                          s1_cmd;
  logic [TSEL_W-1:0]             s1_tsel;
  logic [IDX_W-1:0]              s1_sidx;
  logic signed [SAMPLE_BITS-1:0] s1_sval;
  logic [LEN_W-1:0]              s1_len;
  logic [FREQ_W-1:0]             s1_bound;
  logic [FREQ_W-1:0]             s1_freq;
  logic [PHASE_W-1:0]            s1_phase;
  logic                          found;
  logic [TSEL_W-1:0]             sel_t;
  logic [LEN_W-1:0]              desc_len;
  logic                          desc_we;

  // stage 2: phase times length
  logic                          s2_valid;
  cmd_t                          s2_cmd;
  logic [TSEL_W-1:0]             s2_t;
  logic [LEN_W-1:0]              s2_len;
  logic [PHASE_W-1:0]            s2_phase;
  logic [TSEL_W-1:0]             s2_tsel;
  logic [IDX_W-1:0]              s2_sidx;
  logic signed [SAMPLE_BITS-1:0] s2_sval;

  // stage 3: index and memory access
  logic                          s3_valid;
  cmd_t                          s3_cmd;
  logic [TSEL_W-1:0]             s3_t;
  logic [LEN_W-1:0]              s3_len;
  logic [PROD_W-1:0]             s3_prod;
  logic [TSEL_W-1:0]             s3_tsel;
  logic [IDX_W-1:0]              s3_sidx;
  logic signed [SAMPLE_BITS-1:0] s3_sval;
  logic [LEN_W-1:0]              idx_hi;
  logic [LEN_W-1:0]              idx;
  logic [LEN_W-1:0]              nxt_raw;
  logic [LEN_W-1:0]              nxt;
  logic [ADDR_W-1:0]             addr_a;
  logic [ADDR_W-1:0]             addr_b;
  logic                          wr_en;

  // stage 4: memory data
  logic                          s4_valid;
  logic [TSEL_W-1:0]             s4_t;
  logic [FRAC_W-1:0]             s4_frac;
  logic signed [SAMPLE_BITS-1:0] rd_a;
  logic signed [SAMPLE_BITS-1:0] rd_b;

  logic signed [SAMPLE_BITS-1:0] wave_mem [MEM_DEPTH];

  // request handshake
  assign busy   = rst;
  assign accept = start && !busy;

  // tables in use, kept clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      tables_in_use <= CNT_MAX;
    end else if (cfg_write) begin
      if (cfg_data == '0) begin
        tables_in_use <= CNT_W'(1);
      end else if (cfg_data > CNT_MAX) begin
        tables_in_use <= CNT_MAX;
      end else begin
        tables_in_use <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd   <= cmd_t'(command);
    s1_tsel  <= table_select;
    s1_sidx  <= sample_index;
    s1_sval  <= sample_value;
    s1_len   <= table_length;
    s1_bound <= frequency_bound;
    s1_freq  <= frequency;
    s1_phase <= phase;
  end

  // first table in use whose bound exceeds the frequency, else the last one
  always_comb begin
    found = 1'b0;
    sel_t = TSEL_W'(tables_in_use - 1'b1);
    for (int i = 0; i < MAX_TABLES; i++) begin
      if (!found && (CNT_W'(i) < tables_in_use) && (s1_freq < bound_table[i])) begin
        sel_t = TSEL_W'(i);
        found = 1'b1;
      end
    end
  end

  // descriptor write, length clamped to 1..MAX_LENGTH
  always_comb begin
    if (s1_len == '0) begin
      desc_len = LEN_W'(1);
    end else if (s1_len > LEN_MAX) begin
      desc_len = LEN_MAX;
    end else begin
      desc_len = s1_len;
    end
  end

  assign desc_we = s1_valid && (s1_cmd == CMD_WRITE_DESC) && ({1'b0, s1_tsel} < TABLES_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TABLES; i++) begin
        length_table[i] <= LEN_MAX;
        bound_table[i]  <= '1;
      end
    end else if (desc_we) begin
      length_table[s1_tsel] <= desc_len;
      bound_table[s1_tsel]  <= s1_bound;
    end
  end

  // select register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd   <= s1_cmd;
    s2_t     <= sel_t;
    s2_len   <= length_table[sel_t];
    s2_phase <= s1_phase;
    s2_tsel  <= s1_tsel;
    s2_sidx  <= s1_sidx;
    s2_sval  <= s1_sval;
  end

  // phase scaled by table length
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_cmd  <= s2_cmd;
    s3_t    <= s2_t;
    s3_len  <= s2_len;
    s3_prod <= PROD_W'(s2_phase) * PROD_W'(s2_len);
    s3_tsel <= s2_tsel;
    s3_sidx <= s2_sidx;
    s3_sval <= s2_sval;
  end

  // entry index and wrapped next index
  assign idx_hi  = s3_prod[PHASE_W +: LEN_W];
  assign idx     = (idx_hi >= s3_len) ? s3_len - 1'b1 : idx_hi;
  assign nxt_raw = idx + 1'b1;
  assign nxt     = (nxt_raw >= s3_len) ? '0 : nxt_raw;
  assign addr_a  = {s3_t, idx[IDX_W-1:0]};
  assign addr_b  = {s3_t, nxt[IDX_W-1:0]};

  assign wr_en = s3_valid && (s3_cmd == CMD_WRITE_SAMPLE)
              && ({1'b0, s3_tsel} < TABLES_LIM) && ({1'b0, s3_sidx} < IDX_LIM);

  // wave memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wave_mem[{s3_tsel, s3_sidx}] <= s3_sval;
    end
    rd_a <= wave_mem[addr_a];
    rd_b <= wave_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid && (s3_cmd == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    s4_t    <= s3_t;
    s4_frac <= s3_prod[PHASE_W-1 -: FRAC_W];
  end

  // linear interpolation and output register
  mwl_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TSEL_W      (TSEL_W)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s4_valid),
    .a          (rd_a),
    .b          (rd_b),
    .frac       (s4_frac),
    .item_table (s4_t),
    .done       (done),
    .sample_out (sample_out),
    .table_used (table_used)
  );

  // every read request gives a result
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_READ)) |-> ##6 done)
    else $error("read request without result");

  // every result comes from a read request
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && (command == CMD_READ), 6))
    else $error("result without read request");

  // chosen table is one in use
  a_table_in_use: assert property (@(posedge clk) disable iff (rst)
    done |-> (CNT_W'(table_used) < tables_in_use))
    else $error("table outside those in use");

  // scaled index always lands inside the chosen table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && (s3_cmd == CMD_READ)) |-> (idx_hi < s3_len) && (s3_len != '0))
    else $error("scaled index outside table");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import mwl_pkg::*;

  localparam int TABLES       = 8;
  localparam int LENGTH       = 4096;
  localparam int BOUND_STEP   = 24'h1C0000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS  = 110;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    cmd_t               cmd;
    logic [2:0]         tsel;
    logic [11:0]        sidx;
    logic signed [15:0] sval;
    logic [12:0]        tlen;
    logic [23:0]        fbound;
    logic [23:0]        freq;
    logic [31:0]        ph;
  } request_t;

  typedef struct {
    logic [15:0] smp;
    logic [2:0]  tsel;
  } lookup_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [CMD_W-1:0] command;
  logic [2:0] table_select;
  logic [11:0] sample_index;
  logic signed [15:0] sample_value;
  logic [12:0] table_length;
  logic [23:0] frequency_bound;
  logic [23:0] frequency;
  logic [31:0] phase;
  logic cfg_write;
  logic [3:0] cfg_data;
  logic done;
  logic signed [15:0] sample_out;
  logic [2:0] table_used;

  // predictor state
  logic signed [15:0] wave_mem [0:TABLES*LENGTH-1];
  int unsigned length_mem [0:TABLES-1];
  logic [23:0] bound_mem [0:TABLES-1];
  logic [3:0] tables_cfg;

  // generator view of the state after every queued request
  int unsigned gen_len [0:TABLES-1];
  logic [23:0] gen_bound [0:TABLES-1];
  logic [3:0] gen_count;
  bit gen_written [0:TABLES*LENGTH-1];

  request_t request_queue[$];
  lookup_t expected_lookups[$];

  logic req_taken;
  int gap_left;
  int burst_left;
  int unsigned cycle_count;
  int unsigned err_count;
  int unsigned reads_checked;
  int unsigned requests_taken;
  int unsigned settings_run;

  mipmap_wavetable_lookup DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .table_select    (table_select),
    .sample_index    (sample_index),
    .sample_value    (sample_value),
    .table_length    (table_length),
    .frequency_bound (frequency_bound),
    .frequency       (frequency),
    .phase           (phase),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .done            (done),
    .sample_out      (sample_out),
    .table_used      (table_used)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    if (err_count < 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  // table pick, phase scaling and interpolation for one read
  function automatic lookup_t predict_lookup(input logic [23:0] freq, input logic [31:0] ph);
    lookup_t res;
    int unsigned n, t, len, idx, nxt, frac;
    logic [63:0] scaled;
    longint a, b, acc, shifted;
    n = (tables_cfg == 0) ? 1 : ((tables_cfg > TABLES) ? TABLES : tables_cfg);
    t = n - 1;
    for (int i = n - 1; i >= 0; i--) begin
      if (freq < bound_mem[i]) t = i;
    end
    len = length_mem[t];
    scaled = 64'(ph) * 64'(len);
    idx = scaled[63:32];
    if (idx >= len) idx = len - 1;
    frac = scaled[31:16];
    nxt = idx + 1;
    if (nxt >= len) nxt = 0;
    a = longint'(wave_mem[t * LENGTH + idx]);
    b = longint'(wave_mem[t * LENGTH + nxt]);
    acc = a * longint'(65536 - frac) + b * longint'(frac) + 64'sd32768;
    shifted = acc >>> 16;
    res.smp = shifted[15:0];
    res.tsel = 3'(t);
    return res;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.cmd = cmd_t'($urandom_range(0, 3));
    r.tsel = 3'($urandom);
    r.sidx = 12'($urandom);
    r.sval = 16'($urandom);
    r.tlen = 13'($urandom);
    r.fbound = 24'($urandom);
    r.freq = 24'($urandom);
    r.ph = $urandom;
    return r;
  endfunction

  // weighted mix: mostly reads over short, ascending-bound tables
  function automatic request_t mixed_request();
    request_t r;
    int unsigned pick;
    r = random_request();
    pick = $urandom_range(0, 99);
    if (pick < 55) r.cmd = CMD_READ;
    else if (pick < 80) r.cmd = CMD_WRITE_SAMPLE;
    else if (pick < 95) r.cmd = CMD_WRITE_DESC;
    else r.cmd = CMD_IDLE;
    if ($urandom_range(0, 1) == 0) r.sidx = 12'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0, 1, 2, 3: r.tlen = 13'($urandom_range(1, 16));
      4, 5: r.tlen = 13'($urandom_range(17, LENGTH));
      6: r.tlen = 13'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: r.tlen = 13'd0;
          1: r.tlen = 13'd1;
          2: r.tlen = 13'd2;
          3: r.tlen = 13'd4096;
          default: r.tlen = 13'h1FFF;
        endcase
      end
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: r.fbound = 24'((r.tsel + 1) * BOUND_STEP);
      4: r.fbound = 24'h000000;
      5: r.fbound = 24'hFFFFFF;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0, 1: r.freq = 24'($urandom_range(0, TABLES) * BOUND_STEP + $urandom_range(0, 2) - 1);
      2: r.freq = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: r.ph = 32'h0000_0000;
      1: r.ph = 32'hFFFF_FFFF;
      default: ;
    endcase
    return r;
  endfunction

  // queue one request; a read first gets writes for any never-written
  // entry that it would interpolate between
  task automatic queue_request(input request_t r);
    int unsigned n, t, len, idx, nxt;
    logic [63:0] scaled;
    request_t w;
    case (r.cmd)
      CMD_WRITE_SAMPLE: gen_written[r.tsel * LENGTH + r.sidx] = 1'b1;
      CMD_WRITE_DESC: begin
        len = r.tlen;
        if (len == 0) len = 1;
        if (len > LENGTH) len = LENGTH;
        gen_len[r.tsel] = len;
        gen_bound[r.tsel] = r.fbound;
      end
      CMD_READ: begin
        n = (gen_count == 0) ? 1 : ((gen_count > TABLES) ? TABLES : gen_count);
        t = n - 1;
        for (int i = n - 1; i >= 0; i--) begin
          if (r.freq < gen_bound[i]) t = i;
        end
        len = gen_len[t];
        scaled = 64'(r.ph) * 64'(len);
        idx = scaled[63:32];
        if (idx >= len) idx = len - 1;
        nxt = idx + 1;
        if (nxt >= len) nxt = 0;
        if (!gen_written[t * LENGTH + idx]) begin
          w = random_request();
          w.cmd = CMD_WRITE_SAMPLE;
          w.tsel = 3'(t);
          w.sidx = 12'(idx);
          request_queue.push_back(w);
          gen_written[t * LENGTH + idx] = 1'b1;
        end
        if (!gen_written[t * LENGTH + nxt]) begin
          w = random_request();
          w.cmd = CMD_WRITE_SAMPLE;
          w.tsel = 3'(t);
          w.sidx = 12'(nxt);
          request_queue.push_back(w);
          gen_written[t * LENGTH + nxt] = 1'b1;
        end
      end
      default: ;
    endcase
    request_queue.push_back(r);
  endtask

  task automatic push_sample(input int t, input int i, input int v);
    request_t r;
    r = random_request();
    r.cmd = CMD_WRITE_SAMPLE;
    r.tsel = 3'(t);
    r.sidx = 12'(i);
    r.sval = 16'(v);
    queue_request(r);
  endtask

  task automatic push_desc(input int t, input int len, input int bound);
    request_t r;
    r = random_request();
    r.cmd = CMD_WRITE_DESC;
    r.tsel = 3'(t);
    r.tlen = 13'(len);
    r.fbound = 24'(bound);
    queue_request(r);
  endtask

  task automatic push_read(input int freq, input logic [31:0] ph);
    request_t r;
    r = random_request();
    r.cmd = CMD_READ;
    r.freq = 24'(freq);
    r.ph = ph;
    queue_request(r);
  endtask

  // wait until every request is taken, every result is in and the pipe is empty
  task automatic settle();
    while (request_queue.size() != 0) @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_count(input logic [3:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    gen_count = value;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  // request driver: bursts of back-to-back requests with random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && req_taken && request_queue.size() != 0) void'(request_queue.pop_front());
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_queue.size() != 0) begin
        start <= 1'b1;
        command <= request_queue[0].cmd;
        table_select <= request_queue[0].tsel;
        sample_index <= request_queue[0].sidx;
        sample_value <= request_queue[0].sval;
        table_length <= request_queue[0].tlen;
        frequency_bound <= request_queue[0].fbound;
        frequency <= request_queue[0].freq;
        phase <= request_queue[0].ph;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: track state on each taken request, check each result
  always @(posedge clk) begin
    lookup_t want;
    int unsigned len;
    req_taken <= start && !busy;
    if (rst) begin
      for (int i = 0; i < TABLES; i++) begin
        length_mem[i] = LENGTH;
        bound_mem[i] = 24'hFFFFFF;
      end
      tables_cfg = 4'(TABLES);
    end else begin
      if (cfg_write) tables_cfg = cfg_data;
      if (done) begin
        if (expected_lookups.size() == 0) begin
          log_mismatch($sformatf("result with no read pending: sample %0d table %0d",
                                 sample_out, table_used));
        end else begin
          want = expected_lookups.pop_front();
          if (sample_out !== want.smp) begin
            log_mismatch($sformatf("sample_out %0d, expected %0d (table %0d)",
                                   sample_out, $signed(want.smp), want.tsel));
          end
          if (table_used !== want.tsel) begin
            log_mismatch($sformatf("table_used %0d, expected %0d", table_used, want.tsel));
          end
          reads_checked++;
        end
      end
      if (start && !busy) begin
        requests_taken++;
        case (command)
          CMD_WRITE_SAMPLE: wave_mem[table_select * LENGTH + sample_index] = sample_value;
          CMD_WRITE_DESC: begin
            len = table_length;
            if (len == 0) len = 1;
            if (len > LENGTH) len = LENGTH;
            length_mem[table_select] = len;
            bound_mem[table_select] = frequency_bound;
          end
          CMD_READ: expected_lookups.push_back(predict_lookup(frequency, phase));
          default: ;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [3:0] counts [0:7];
    counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd6, 4'd8};
    rst = 1'b1;
    start = 1'b0;
    command = CMD_IDLE;
    table_select = '0;
    sample_index = '0;
    sample_value = '0;
    table_length = '0;
    frequency_bound = '0;
    frequency = '0;
    phase = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    req_taken = 1'b0;
    gap_left = 0;
    burst_left = 0;
    cycle_count = 0;
    err_count = 0;
    reads_checked = 0;
    requests_taken = 0;
    settings_run = 0;
    for (int i = 0; i < TABLES; i++) begin
      gen_len[i] = LENGTH;
      gen_bound[i] = 24'hFFFFFF;
    end
    gen_count = 4'(TABLES);
    for (int i = 0; i < TABLES * LENGTH; i++) begin
      gen_written[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_table_count(counts[0]);

    // directed: length clamps, bound edges, wrap, extremes, idle command
    push_desc(0, 0, 0);
    push_desc(1, 8191, 100);
    push_desc(2, 2, 24'hFFFFFF);
    push_sample(2, 0, 32767);
    push_sample(2, 1, -32768);
    push_read(0, 32'h0000_0000);
    push_read(99, 32'hFFFF_FFFF);
    push_read(100, 32'h7FFF_FFFF);
    push_read(100, 32'hC000_0000);
    push_read(100, 32'h4000_0000);
    push_read(24'hFFFFFF, 32'h4000_0000);
    push_sample(7, 4095, -32768);
    push_sample(7, 0, 32767);
    push_read(24'hFFFFFF, 32'hFFFF_FFFF);
    push_desc(0, 1, 24'hFFFFFF);
    push_read(5, 32'h1234_5678);
    push_read(24'hFFFFFE, 32'hFFFF_FFFF);
    push_desc(3, 4096, 24'h000001);
    push_read(0, 32'h8000_0000);
    push_sample(3, 4095, 1);
    push_read(0, 32'hFFFF_FFFF);
    begin
      request_t r;
      r = random_request();
      r.cmd = CMD_IDLE;
      queue_request(r);
    end
    push_read(1, 32'h0000_0001);

    // random phases over several table counts
    for (int p = 0; p < 8; p++) begin
      if (p != 0) begin
        settle();
        write_table_count(counts[p]);
      end
      repeat (PHASE_ITEMS) queue_request(mixed_request());
    end
    settle();

    $display("covered %0d requests, %0d reads checked", requests_taken, reads_checked);
    $display("over %0d table-count settings incl. 0, 1, 8 and 15", settings_run);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
